// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define CSC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Checked at every edge, reset included.
`define CSC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

// File: rtl/core/csc_pkg.sv
package csc_pkg;

	localparam int MUL_A_W   = 32;
	localparam int MUL_B_W   = 28;
	localparam int PROD_W    = MUL_A_W + MUL_B_W;
	localparam int DEN_W     = 23;
	localparam int QUO_W     = 16;
	localparam int MUL_STEPS = MUL_A_W;
	localparam int DIV_STEPS = PROD_W;
	localparam int MUL_CNT_W = $clog2(MUL_STEPS);
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [4:0]  MIN_LEN    = 5'd11;
	localparam int          FLAG_WHEEL = 0;
	localparam int          FLAG_CRANK = 1;
	localparam logic [11:0] CIRC_RESET = 12'd2100;
	localparam logic [15:0] SPD_NUM    = 16'd36864;
	localparam logic [6:0]  SPD_DEN    = 7'd100;
	localparam logic [22:0] CAD_NUM    = 23'd6144000;
	localparam logic [15:0] CAD_LIMIT  = 16'd25500;
	localparam logic [15:0] SPEED_MAX  = 16'hFFFF;

	typedef struct packed {
		logic [4:0]  packet_length;
		logic [7:0]  flags;
		logic [31:0] wheel_revs;
		logic [15:0] wheel_time;
		logic [15:0] crank_revs;
		logic [15:0] crank_time;
	} csc_in_t;

	typedef struct packed {
		logic        speed_updated;
		logic [15:0] speed_kmh_x100;
		logic        cadence_updated;
		logic [14:0] cadence_rpm_x100;
		logic [15:0] crank_revs_seen;
	} csc_out_t;

	typedef struct packed {
		logic             done;
		logic             ovf;
		logic [QUO_W-1:0] quo;
	} csc_div_res_t;

endpackage

// File: rtl/core/csc_mul.sv
module csc_mul (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [csc_pkg::MUL_A_W-1:0]  a,
	input  logic [csc_pkg::MUL_B_W-1:0]  b,
	output logic                         done,
	output logic [csc_pkg::PROD_W-1:0]   prod
);
	import csc_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic [MUL_B_W-1:0]   hi_q;
	logic [MUL_A_W-1:0]   lo_q;
	logic [MUL_B_W-1:0]   b_q;
	logic [MUL_B_W:0]     sum;

	// One bit of the multiplier per cycle, least significant first.
	assign sum = lo_q[0] ? ({1'b0, hi_q} + {1'b0, b_q}) : {1'b0, hi_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == MUL_CNT_W'(MUL_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			hi_q <= '0;
			lo_q <= a;
			b_q  <= b;
		end else if (busy_q) begin
			hi_q <= sum[MUL_B_W:1];
			lo_q <= {sum[0], lo_q[MUL_A_W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = {hi_q, lo_q};

endmodule

// File: rtl/core/csc_div.sv
module csc_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [csc_pkg::PROD_W-1:0]  dividend,
	input  logic [csc_pkg::DEN_W-1:0]   divisor,
	output csc_pkg::csc_div_res_t       res
);
	import csc_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0]     rem_q;
	logic [DEN_W-1:0]     den_q;
	logic [PROD_W-1:0]    dvd_q;
	logic [QUO_W-1:0]     quo_q;
	logic                 ovf_q;
	logic [DEN_W:0]       trial;
	logic [DEN_W:0]       diff;
	logic                 ge;

	// Restoring division, one quotient bit per cycle. Quotient bits that
	// fall off the top of the kept field mark an overflow.
	assign trial = {rem_q, dvd_q[PROD_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= divisor;
			dvd_q <= dividend;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			dvd_q <= {dvd_q[PROD_W-2:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], ge};
			ovf_q <= ovf_q | quo_q[QUO_W-1];
		end
	end

	assign res.done = done_q;
	assign res.ovf  = ovf_q;
	assign res.quo  = quo_q;

endmodule

// File: rtl/core/cycling_speed_cadence_computer_unit.sv
// Cycling speed and cadence computer.
// The meas channel (meas_valid, meas_stall, meas) takes one decoded
// measurement per item. The res channel (res_valid, res_stall, res) returns
// exactly one result item for each measurement, in order. The cfg channel
// (cfg_valid, cfg_ready, cfg_data) writes the wheel circumference and is
// always ready; the user must write it only while no item is in flight,
// and the block itself does not enforce this. An item that computes
// nothing goes from S_IDLE straight to S_FIN. A speed or a cadence each
// adds a pass through its start, multiply and divide states. Each one
// runs a 32-step bit-serial multiplier and then a 60-step bit-serial
// divider, both shared between speed and cadence.
// A new item is accepted in the cycle after the previous result is loaded
// into the output register; no new item is accepted while one is in flight.
// When the receiver stalls, the result stays in the output register and the
// block finishes the next item, then waits for the output register to free.
// Reset clears all held values and sets the circumference to 2100 mm.
module cycling_speed_cadence_computer_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              meas_valid,
	output logic              meas_stall,
	input  csc_pkg::csc_in_t  meas,
	output logic              res_valid,
	input  logic              res_stall,
	output csc_pkg::csc_out_t res,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [11:0]       cfg_data
);
	import csc_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_SPD  = 8'b0000_0010,
		S_SMUL = 8'b0000_0100,
		S_SDIV = 8'b0000_1000,
		S_CAD  = 8'b0001_0000,
		S_CMUL = 8'b0010_0000,
		S_CDIV = 8'b0100_0000,
		S_FIN  = 8'b1000_0000
	} state_t;

	state_t       state_q;
	logic [11:0]  circ_q;
	logic [31:0]  prev_wrev_q;
	logic [15:0]  prev_wtime_q;
	logic [15:0]  prev_crev_q;
	logic [15:0]  prev_ctime_q;
	logic [15:0]  held_speed_q;
	logic [14:0]  held_cad_q;
	logic [15:0]  held_crank_q;
	logic         spd_upd_q;
	logic         cad_upd_q;
	logic         cad_go_q;
	logic         res_valid_q;
	csc_out_t     res_q;
	logic [31:0]  wdrev_q;
	logic [15:0]  cdrev_q;
	logic [DEN_W-1:0] sden_q;
	logic [15:0]  cden_q;

	logic         meas_acc;
	logic         meas_ok;
	logic         has_wheel;
	logic         has_crank;
	logic [31:0]  wdrev;
	logic [15:0]  wdt;
	logic [15:0]  cdrev;
	logic [15:0]  cdt;
	logic         spd_go;
	logic         cad_go;
	logic         load;
	logic         cad_ok;

	logic                 mul_start;
	logic [MUL_A_W-1:0]   mul_a;
	logic [MUL_B_W-1:0]   mul_b;
	logic                 mul_done;
	logic [PROD_W-1:0]    mul_prod;
	logic                 div_start;
	logic [DEN_W-1:0]     div_den;
	csc_div_res_t         div_res;

	assign meas_stall = (state_q != S_IDLE);
	assign meas_acc   = meas_valid && !meas_stall;
	assign cfg_ready  = 1'b1;

	assign meas_ok   = meas.packet_length >= MIN_LEN;
	assign has_wheel = meas_ok && meas.flags[FLAG_WHEEL];
	assign has_crank = meas_ok && meas.flags[FLAG_CRANK];
	assign wdrev     = meas.wheel_revs - prev_wrev_q;
	assign wdt       = meas.wheel_time - prev_wtime_q;
	assign cdrev     = meas.crank_revs - prev_crev_q;
	assign cdt       = meas.crank_time - prev_ctime_q;
	assign spd_go    = has_wheel && (prev_wrev_q != '0) && (wdt != '0);
	assign cad_go    = has_crank && (prev_crev_q != '0) && (cdt != '0) && (cdrev != '0);

	assign mul_start = (state_q == S_SPD) || (state_q == S_CAD);
	assign mul_a     = (state_q == S_SPD) ? wdrev_q : MUL_A_W'(cdrev_q);
	assign mul_b     = (state_q == S_SPD) ? (MUL_B_W'(circ_q) * MUL_B_W'(SPD_NUM))
	                                      : MUL_B_W'(CAD_NUM);
	assign div_start = ((state_q == S_SMUL) || (state_q == S_CMUL)) && mul_done;
	assign div_den   = (state_q == S_SMUL) ? sden_q : DEN_W'(cden_q);

	assign cad_ok = !div_res.ovf && (div_res.quo != '0) && (div_res.quo < CAD_LIMIT);
	assign load   = (state_q == S_FIN) && (!res_valid_q || !res_stall);

	csc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	csc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mul_prod),
		.divisor  (div_den),
		.res      (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			circ_q       <= CIRC_RESET;
			prev_wrev_q  <= '0;
			prev_wtime_q <= '0;
			prev_crev_q  <= '0;
			prev_ctime_q <= '0;
			held_speed_q <= '0;
			held_cad_q   <= '0;
			held_crank_q <= '0;
			spd_upd_q    <= 1'b0;
			cad_upd_q    <= 1'b0;
			cad_go_q     <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				circ_q <= cfg_data;
			end
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (meas_acc) begin
						spd_upd_q <= 1'b0;
						cad_upd_q <= 1'b0;
						cad_go_q  <= cad_go;
						if (has_wheel) begin
							prev_wrev_q  <= meas.wheel_revs;
							prev_wtime_q <= meas.wheel_time;
						end
						if (has_crank) begin
							prev_crev_q  <= meas.crank_revs;
							prev_ctime_q <= meas.crank_time;
							held_crank_q <= meas.crank_revs;
						end
						if (spd_go) begin
							state_q <= S_SPD;
						end else if (cad_go) begin
							state_q <= S_CAD;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_SPD: begin
					state_q <= S_SMUL;
				end
				S_SMUL: begin
					if (mul_done) begin
						state_q <= S_SDIV;
					end
				end
				S_SDIV: begin
					if (div_res.done) begin
						held_speed_q <= div_res.ovf ? SPEED_MAX : div_res.quo;
						spd_upd_q    <= 1'b1;
						state_q      <= cad_go_q ? S_CAD : S_FIN;
					end
				end
				S_CAD: begin
					state_q <= S_CMUL;
				end
				S_CMUL: begin
					if (mul_done) begin
						state_q <= S_CDIV;
					end
				end
				S_CDIV: begin
					if (div_res.done) begin
						if (cad_ok) begin
							held_cad_q <= div_res.quo[14:0];
							cad_upd_q  <= 1'b1;
						end
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (meas_acc) begin
			wdrev_q <= wdrev;
			cdrev_q <= cdrev;
			sden_q  <= DEN_W'(wdt) * DEN_W'(SPD_DEN);
			cden_q  <= cdt;
		end
		if (load) begin
			res_q.speed_updated    <= spd_upd_q;
			res_q.speed_kmh_x100   <= held_speed_q;
			res_q.cadence_updated  <= cad_upd_q;
			res_q.cadence_rpm_x100 <= held_cad_q;
			res_q.crank_revs_seen  <= held_crank_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// File: rtl/core/csc_chk.sv
`include "assert_macros.svh"

module csc_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              meas_valid,
	input logic              meas_stall,
	input logic              res_valid,
	input logic              res_stall,
	input csc_pkg::csc_out_t res
);
	import csc_pkg::*;

	// Accepting an item makes the block busy in the next cycle.
	`CSC_ASSERT(a_busy_after_accept, meas_valid && !meas_stall |=> meas_stall, "no stall after accept")

	// A result never appears in the cycle right after an item is accepted.
	`CSC_ASSERT(a_no_early_result, meas_valid && !meas_stall |=> !$rose(res_valid), "result too early")

	// A stalled result stays valid and unchanged.
	`CSC_ASSERT(a_res_hold, res_valid && res_stall |=> res_valid && $stable(res), "stalled result moved")

	// The held cadence always lies below the acceptance limit.
	`CSC_ASSERT(a_cad_range, res_valid |-> 16'(res.cadence_rpm_x100) < CAD_LIMIT, "cadence out of range")

	// No result is offered while reset is applied.
	`CSC_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !res_valid, "result valid in reset")

endmodule

bind cycling_speed_cadence_computer_unit csc_chk u_csc_chk (.*);
